// ===== sv/lipcr_pkg.sv =====
package lipcr_pkg;

    // fixed field widths of the request and response items
    localparam int SET_IDX_W = 11;
    localparam int WAY_FLD_W = 4;

    // request codes
    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_FLD_W-1:0] way;
        logic                 hit;
        logic                 is_writeback;
    } t_req;

    typedef struct packed {
        logic [WAY_FLD_W-1:0] victim_way;
        logic                 from_invalid;
        logic                 no_victim;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic rd_en;      // read one set row
        logic rd_sel_in;  // row address from the incoming request
        logic red_step;   // one step of the set index reduction
        logic clr_step;   // write one reset row during the clearing pass
        logic wr_row;     // write back the modified row of an update
        logic out_load;   // load the response register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic red_needed; // set index needs a modulo reduction
        logic red_last;   // last reduction step
        logic clr_last;   // last row of the clearing pass
        logic req_find;   // captured request is a find-victim
    } t_dp_sts;

endpackage

// ===== sv/lipcr_chan_if.sv =====
interface lipcr_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lipcr_ram.sv =====
module lipcr_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== sv/lipcr_dpath.sv =====
module lipcr_dpath #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lipcr_pkg::t_req    i_req,
    input  lipcr_pkg::t_dp_cmd i_cmd,
    output lipcr_pkg::t_dp_sts o_sts,
    output lipcr_pkg::t_rsp    o_rsp
);
    import lipcr_pkg::*;

    localparam int RW    = $clog2(WAYS);
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W = WAYS * (RW + 1);
    localparam bit POW2  = ((SETS & (SETS - 1)) == 0);
    localparam bit NEED_RED = (SETS < (1 << SET_IDX_W)) && !POW2;

    // captured request
    logic                 r_req_type;
    logic [WAY_FLD_W-1:0] r_way;
    logic                 r_hit;
    logic                 r_wb;
    logic [SW-1:0]        r_set;
    logic [SW-1:0]        r_clr;
    t_rsp                 r_rsp;

    logic [SW-1:0]    idx_now;
    logic [SW-1:0]    red_result;
    logic             red_last;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] reset_row;
    logic [ROW_W-1:0] new_row;
    logic [ROW_W-1:0] wr_data;
    logic [SW-1:0]    wr_addr;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;
    logic [RW-1:0]    ranks [WAYS];
    logic             valids [WAYS];
    t_rsp             find_rsp;
    logic             way_ok;
    logic             do_promote;
    logic             do_insert;

    // set index reduction modulo SETS
    generate
        if (SETS == 1) begin : g_one_set
            assign idx_now    = '0;
            assign red_result = '0;
            assign red_last   = 1'b1;
        end else if (!NEED_RED) begin : g_direct
            if (SETS >= (1 << SET_IDX_W)) begin : g_wide
                assign idx_now = SW'(i_req.set_index);
            end else begin : g_mask
                assign idx_now = i_req.set_index[SW-1:0];
            end
            assign red_result = '0;
            assign red_last   = 1'b1;
        end else begin : g_reduce
            localparam int RK = SET_IDX_W + SW;
            localparam int MW = SET_IDX_W + 2;
            localparam longint RM = ((longint'(1) << RK) + longint'(SETS) - 1)
                                    / longint'(SETS);

            logic [SET_IDX_W-1:0]    r_idx;
            logic [SET_IDX_W-1:0]    r_quo;
            logic                    r_cnt;
            logic [SET_IDX_W+MW-1:0] prod;
            logic [SET_IDX_W-1:0]    rem_full;

            // reciprocal multiply: quotient on the first step, remainder on the second
            assign prod       = (SET_IDX_W+MW)'(r_idx) * (SET_IDX_W+MW)'(RM);
            assign rem_full   = r_idx - SET_IDX_W'(r_quo * SET_IDX_W'(SETS));
            assign red_result = SW'(rem_full);
            assign red_last   = r_cnt;
            assign idx_now    = '0;

            always_ff @(posedge i_clk) begin
                if (i_cmd.load_req) begin
                    r_idx <= i_req.set_index;
                    r_cnt <= 1'b0;
                end else if (i_cmd.red_step) begin
                    r_quo <= SET_IDX_W'(prod >> RK);
                    r_cnt <= 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req.req_type;
            r_way      <= i_req.way;
            r_hit      <= i_req.hit;
            r_wb       <= i_req.is_writeback;
            r_set      <= idx_now;
        end else if (i_cmd.red_step && red_last) begin
            r_set <= red_result;
        end
        if (i_cmd.out_load) begin
            r_rsp <= find_rsp;
        end
    end

    // clearing pass row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + SW'(1);
        end
    end

    // row layout: ranks in the low part, valid bits on top
    always_comb begin
        reset_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            reset_row[w*RW +: RW] = RW'(w);
            ranks[w]  = rd_row[w*RW +: RW];
            valids[w] = rd_row[WAYS*RW + w];
        end
    end

    // victim search: lowest invalid way, else lowest way at the lru rank, else no_victim
    always_comb begin
        logic found_inv;
        logic found_lru;
        logic [WAY_FLD_W-1:0] inv_way;
        logic [WAY_FLD_W-1:0] lru_way;
        found_inv = 1'b0;
        found_lru = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found_inv && !valids[i]) begin
                found_inv = 1'b1;
                inv_way   = WAY_FLD_W'(i);
            end
            if (!found_lru && (ranks[i] == RW'(WAYS - 1))) begin
                found_lru = 1'b1;
                lru_way   = WAY_FLD_W'(i);
            end
        end
        if (found_inv) begin
            find_rsp = '{victim_way: inv_way, from_invalid: 1'b1, no_victim: 1'b0};
        end else if (found_lru) begin
            find_rsp = '{victim_way: lru_way, from_invalid: 1'b0, no_victim: 1'b0};
        end else begin
            find_rsp = '{victim_way: '0, from_invalid: 1'b0, no_victim: 1'b1};
        end
    end

    assign way_ok     = (int'(r_way) < WAYS);
    assign do_promote = r_hit && !r_wb;
    assign do_insert  = !r_hit;

    // rank update: promote to mru or insert at lru
    always_comb begin
        logic [RW-1:0] sel_rank;
        sel_rank = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (int'(r_way) == i) begin
                sel_rank = ranks[i];
            end
        end
        new_row = rd_row;
        for (int i = 0; i < WAYS; i++) begin
            if (int'(r_way) == i) begin
                if (do_promote) begin
                    new_row[i*RW +: RW] = '0;
                end else begin
                    new_row[i*RW +: RW]   = RW'(WAYS - 1);
                    new_row[WAYS*RW + i] = 1'b1;
                end
            end else if (do_promote && (ranks[i] < sel_rank)) begin
                new_row[i*RW +: RW] = ranks[i] + RW'(1);
            end else if (!do_promote && (ranks[i] > sel_rank)) begin
                new_row[i*RW +: RW] = ranks[i] - RW'(1);
            end
        end
    end

    assign wr_en   = i_cmd.clr_step ||
                     (i_cmd.wr_row && way_ok && (do_promote || do_insert));
    assign wr_data = i_cmd.clr_step ? reset_row : new_row;
    assign wr_addr = i_cmd.clr_step ? r_clr : r_set;
    assign rd_addr = i_cmd.rd_sel_in ? idx_now : r_set;

    lipcr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_row)
    );

    assign o_sts.red_needed = NEED_RED;
    assign o_sts.red_last   = red_last;
    assign o_sts.clr_last   = (r_clr == SW'(SETS - 1));
    assign o_sts.req_find   = (r_req_type == REQ_FIND);
    assign o_rsp            = r_rsp;
endmodule

// ===== sv/lipcr_ctrl.sv =====
module lipcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lipcr_pkg::t_dp_cmd o_cmd,
    input  lipcr_pkg::t_dp_sts i_sts
);
    import lipcr_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_EXEC
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    if (i_sts.red_needed) begin
                        n_state = S_REDUCE;
                    end else begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel_in = 1'b1;
                        n_state       = S_EXEC;
                    end
                end
            end
            S_REDUCE: begin
                cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.req_find) begin
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.wr_row = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_out_valid = cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("response register overwritten while pending");

    // one request at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while one is in flight");

    // clearing pass covers every row before requests are taken
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_sts.clr_last) |=> (r_state == S_CLEAR))
        else $error("clearing pass ended early");

    // a find-victim request with a free response slot yields a response
    a_find_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_sts.req_find && out_free) |=> o_out_valid)
        else $error("find-victim response lost");
endmodule

// ===== sv/lip_cache_replacement_top.sv =====
// lru insertion policy replacement state for a set-associative cache
//
// i_req: request channel (valid/ready). find-victim requests name a set and
//   get one transfer on o_rsp; update requests (hit promote, writeback hit,
//   miss fill at lru rank) produce no transfer
// o_rsp: response channel (valid/ready) carrying victim_way, from_invalid
//   and no_victim, held in a response register
// each request is the accept step plus one read-modify-write of the set row
//   in a registered-read row ram; o_rsp.valid is registered and rises when
//   the response register is loaded in the last step. when SETS is not a
//   power of two and below 2048 the set index is first reduced by a
//   reciprocal multiply (quotient, remainder); the row read is its own step
// reset: a clearing pass writes the reset row into all SETS rows, one row
//   per cycle, with i_req.ready low until the pass is done
// a stalled receiver keeps its response; the next request is still taken,
//   and a find-victim request waits in its last step until the response
//   register frees up
module lip_cache_replacement_top #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lipcr_chan_if.sink    i_req,
    lipcr_chan_if.source  o_rsp
);
    import lipcr_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_req    req;
    t_rsp    rsp;
    logic    in_ready;
    logic    out_valid;

    assign req = i_req.data;

    // sequencer: clearing pass, index reduction, row read, write back
    lipcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // row storage, victim search and rank update
    lipcr_dpath #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (rsp)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp;
endmodule

// ===== tb/lip_cache_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module lip_cache_replacement_top_tb;
    import lipcr_pkg::*;

    localparam int NUM_WAYS  = 16;
    localparam int NUM_SETS  = 2048;
    localparam int MAX_CYCLES = 200000;
    localparam int RAND_ITEMS = 550;

    logic i_clk;
    logic i_rst_n;

    lipcr_chan_if #(.t_payload(t_req)) req_if ();
    lipcr_chan_if #(.t_payload(t_rsp)) rsp_if ();

    lip_cache_replacement_top #(
        .WAYS (NUM_WAYS),
        .SETS (NUM_SETS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // replacement state mirror, one rank and one valid bit per way
    logic [WAY_FLD_W-1:0] rank_tbl [NUM_SETS][NUM_WAYS];
    logic                 line_vld [NUM_SETS][NUM_WAYS];

    t_rsp victim_q [$];
    int   err_count;
    int   cycle_count;
    bit   idle_on;
    logic [SET_IDX_W-1:0] hot_set [4];

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // cycle limit, covers the clearing pass and worst-case stalls many times over
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_req mk_req(logic kind, logic [SET_IDX_W-1:0] set_idx,
                                    logic [WAY_FLD_W-1:0] w, logic h, logic wb);
        t_req r;
        r.req_type     = kind;
        r.set_index    = set_idx;
        r.way          = w;
        r.hit          = h;
        r.is_writeback = wb;
        return r;
    endfunction

    // first invalid way wins, else the lowest way at the least recent rank, else no_victim
    function automatic t_rsp pick_victim(logic [SET_IDX_W-1:0] set_idx);
        t_rsp v;
        int   s;
        s = int'(set_idx) % NUM_SETS;
        v.victim_way   = '0;
        v.from_invalid = 1'b0;
        v.no_victim    = 1'b1;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (!line_vld[s][i]) begin
                v.victim_way   = WAY_FLD_W'(i);
                v.from_invalid = 1'b1;
                v.no_victim    = 1'b0;
                return v;
            end
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (rank_tbl[s][i] == WAY_FLD_W'(NUM_WAYS - 1)) begin
                v.victim_way = WAY_FLD_W'(i);
                v.no_victim  = 1'b0;
                return v;
            end
        end
        return v;
    endfunction

    // hit promotes to rank 0, writeback hit is a no-op, miss fill goes to lru rank
    function automatic void apply_update(t_req r);
        int s;
        int w;
        logic [WAY_FLD_W-1:0] old_rank;
        s = int'(r.set_index) % NUM_SETS;
        w = int'(r.way);
        if (w >= NUM_WAYS) return;
        old_rank = rank_tbl[s][w];
        if (r.hit) begin
            if (!r.is_writeback) begin
                for (int i = 0; i < NUM_WAYS; i++)
                    if (rank_tbl[s][i] < old_rank) rank_tbl[s][i] = rank_tbl[s][i] + 1'b1;
                rank_tbl[s][w] = '0;
            end
        end else begin
            for (int i = 0; i < NUM_WAYS; i++)
                if (rank_tbl[s][i] > old_rank) rank_tbl[s][i] = rank_tbl[s][i] - 1'b1;
            rank_tbl[s][w] = WAY_FLD_W'(NUM_WAYS - 1);
            line_vld[s][w] = 1'b1;
        end
    endfunction

    task automatic report(string field, logic [WAY_FLD_W-1:0] got, logic [WAY_FLD_W-1:0] want);
        err_count++;
        if (err_count <= 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    endtask

    // one request transfer; the expectation is formed at the accepting edge
    task automatic send_req(t_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        if (r.req_type == REQ_FIND)
            victim_q.push_back(pick_victim(r.set_index));
        else
            apply_update(r);
    endtask

    // drop valid before the next accepting edge, then wait for every response
    task automatic wait_drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
    endtask

    // response side: random stall per transfer, checked at the accepting edge
    initial begin
        t_rsp want;
        t_rsp got;
        int   n;
        rsp_if.ready <= 1'b0;
        forever begin
            n = idle_on ? $urandom_range(0, 5) : 0;
            if (n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            got = rsp_if.data;
            if (victim_q.size() == 0) begin
                err_count++;
                $display("unexpected response at %0t", $realtime);
            end else begin
                want = victim_q.pop_front();
                if (got.victim_way !== want.victim_way)
                    report("victim_way", got.victim_way, want.victim_way);
                if (got.from_invalid !== want.from_invalid)
                    report("from_invalid", got.from_invalid, want.from_invalid);
                if (got.no_victim !== want.no_victim)
                    report("no_victim", got.no_victim, want.no_victim);
            end
            @(negedge i_clk);
        end
    end

    // untouched sets give way 0; a hit on an invalid way promotes it but keeps it invalid
    task automatic test_fresh_sets();
        idle_on = 1'b1;
        send_req(mk_req(REQ_FIND,   11'd0,    4'd15, 1'b1, 1'b1));
        send_req(mk_req(REQ_FIND,   11'd2047, 4'd0,  1'b0, 1'b0));
        send_req(mk_req(REQ_UPDATE, 11'd0,    4'd3,  1'b1, 1'b0));
        send_req(mk_req(REQ_FIND,   11'd0,    4'd0,  1'b0, 1'b0));
    endtask

    // fill a whole set with miss fills, then evict from the lru rank
    task automatic test_fill_and_evict();
        idle_on = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
            send_req(mk_req(REQ_UPDATE, 11'd2047, WAY_FLD_W'(w), 1'b0, 1'(w)));
        send_req(mk_req(REQ_FIND,   11'd2047, 4'd7,  1'b0, 1'b0));
        send_req(mk_req(REQ_UPDATE, 11'd2047, 4'd15, 1'b1, 1'b0));
        send_req(mk_req(REQ_UPDATE, 11'd2047, 4'd14, 1'b1, 1'b1));
        send_req(mk_req(REQ_FIND,   11'd2047, 4'd0,  1'b1, 1'b1));
        // hold off until every response is back
        wait_drain();
    endtask

    // mostly a few hot sets so they fill up and reach the lru eviction path
    task automatic test_random();
        t_req r;
        t_rsp v;
        int   sel;
        hot_set[0] = 11'd0;
        hot_set[1] = 11'd2047;
        hot_set[2] = SET_IDX_W'($urandom);
        hot_set[3] = SET_IDX_W'($urandom);
        for (int k = 0; k < RAND_ITEMS; k++) begin
            // alternate stretches with and without idling on both sides
            if (k % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (k == RAND_ITEMS / 2) wait_drain();
            r = mk_req(REQ_FIND, SET_IDX_W'($urandom), WAY_FLD_W'($urandom),
                       1'($urandom), 1'($urandom));
            if ($urandom_range(0, 4) != 0) r.set_index = hot_set[$urandom_range(0, 3)];
            sel = $urandom_range(0, 99);
            if (sel >= 40) begin
                r.req_type = REQ_UPDATE;
                if (sel < 65) begin
                    // well-formed miss: fill the way just chosen as victim
                    v     = pick_victim(r.set_index);
                    r.way = v.victim_way;
                    r.hit = 1'b0;
                end else if (sel < 75) begin
                    r.hit = 1'b0;
                end else if (sel < 93) begin
                    r.hit          = 1'b1;
                    r.is_writeback = 1'b0;
                end else begin
                    r.hit          = 1'b1;
                    r.is_writeback = 1'b1;
                end
            end
            send_req(r);
        end
    endtask

    initial begin
        err_count   = 0;
        cycle_count = 0;
        idle_on     = 1'b0;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++) begin
                rank_tbl[s][w] = WAY_FLD_W'(w);
                line_vld[s][w] = 1'b0;
            end
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fresh_sets();
        test_fill_and_evict();
        test_random();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
